>>> rtl/age_pkg.sv
// ---------------------------------------------------------------------------
// age_pkg: shared types and constants for the anagram group engine
// Request codes, letter decode, controller/datapath command and status.
// ---------------------------------------------------------------------------
package age_pkg;

  localparam int ALPHA_SIZE     = 26;
  localparam int LETTER_W       = $clog2(ALPHA_SIZE);
  localparam int DEF_MAX_WORDS  = 64;
  localparam int DEF_COUNT_BITS = 8;
  localparam int OUT_IDX_W      = 6;

  localparam logic [1:0] REQ_CHAR   = 2'd0;
  localparam logic [1:0] REQ_CLOSE  = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  typedef struct packed {
    logic                hit;
    logic [LETTER_W-1:0] idx;
  } letter_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic char_upd;
    logic close;
    logic clear;
    logic i_zero;
    logic rd_vec_i;
    logic cap_cur;
    logic rd_ord_jm1;
    logic rd_vec_ord;
    logic shift;
    logic place;
    logic rd_ord_i;
    logic emit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic wc_zero;
    logic i_eq_n;
    logic i_zero;
    logic j_one;
    logic gt;
    logic last;
    logic out_free;
  } sts_t;

  // Case-folded letter number; hit is low for non-letters
  function automatic letter_t letter_of(input logic [7:0] c);
    letter_t r;
    r.hit = 1'b0;
    r.idx = '0;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      r.hit = 1'b1;
      r.idx = LETTER_W'(c - CH_UPPER_A);
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      r.hit = 1'b1;
      r.idx = LETTER_W'(c - CH_LOWER_A);
    end
    return r;
  endfunction

endpackage

>>> rtl/age_chan_if.sv
// ---------------------------------------------------------------------------
// age channel interfaces
// Valid/ready channels for request beats and result beats.
// ---------------------------------------------------------------------------
interface age_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] char_code;

  modport source (output valid, output req_type, output char_code, input ready);
  modport sink   (input valid, input req_type, input char_code, output ready);
endinterface

interface age_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] word_index;
  logic [5:0] group_index;
  logic       new_group;
  logic       last_result;
  logic       overflow;

  modport source (output valid, output word_index, output group_index, output new_group,
                  output last_result, output overflow, input ready);
  modport sink   (input valid, input word_index, input group_index, input new_group,
                  input last_result, input overflow, output ready);
endinterface

>>> rtl/age_ctrl.sv
// ---------------------------------------------------------------------------
// age_ctrl: sequencer of the anagram group engine
// Takes request beats, then runs the insertion sort and the result walk.
// ---------------------------------------------------------------------------
module age_ctrl
  import age_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] req_type,
  output logic       in_ready,
  output cmd_t       cmd,
  input  sts_t       sts
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LD    = 4'd1;
  localparam logic [3:0] ST_LDW   = 4'd2;
  localparam logic [3:0] ST_RO    = 4'd3;
  localparam logic [3:0] ST_RV    = 4'd4;
  localparam logic [3:0] ST_CMP   = 4'd5;
  localparam logic [3:0] ST_PLACE = 4'd6;
  localparam logic [3:0] ST_OO    = 4'd7;
  localparam logic [3:0] ST_OV    = 4'd8;
  localparam logic [3:0] ST_OE    = 4'd9;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (req_type)
            REQ_CHAR:  cmd.char_upd = 1'b1;
            REQ_CLOSE: cmd.close = 1'b1;
            REQ_FINISH: begin
              if (sts.wc_zero) begin
                cmd.clear = 1'b1;
              end else begin
                cmd.i_zero = 1'b1;
                state_next = ST_LD;
              end
            end
            default: ;
          endcase
        end
      end
      // sort: pick up word i
      ST_LD: begin
        if (sts.i_eq_n) begin
          cmd.i_zero = 1'b1;
          state_next = ST_OO;
        end else begin
          cmd.rd_vec_i = 1'b1;
          state_next = ST_LDW;
        end
      end
      ST_LDW: begin
        cmd.cap_cur = 1'b1;
        state_next  = sts.i_zero ? ST_PLACE : ST_RO;
      end
      ST_RO: begin
        cmd.rd_ord_jm1 = 1'b1;
        state_next     = ST_RV;
      end
      ST_RV: begin
        cmd.rd_vec_ord = 1'b1;
        state_next     = ST_CMP;
      end
      ST_CMP: begin
        if (sts.gt) begin
          cmd.shift  = 1'b1;
          state_next = sts.j_one ? ST_PLACE : ST_RO;
        end else begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: begin
        cmd.place  = 1'b1;
        state_next = ST_LD;
      end
      // result walk
      ST_OO: begin
        cmd.rd_ord_i = 1'b1;
        state_next   = ST_OV;
      end
      ST_OV: begin
        cmd.rd_vec_ord = 1'b1;
        state_next     = ST_OE;
      end
      ST_OE: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last) begin
            cmd.clear  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_OO;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/age_dp.sv
// ---------------------------------------------------------------------------
// age_dp: datapath of the anagram group engine
// Current word counters, vector store, sort order store, result register.
// ---------------------------------------------------------------------------
module age_dp
  import age_pkg::*;
#(
  parameter int MAX_WORDS  = DEF_MAX_WORDS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] char_code,
  input  cmd_t       cmd,
  output sts_t       sts,
  age_out_if.source  out_ch
);

  localparam int IDX_W = $clog2(MAX_WORDS);
  localparam int CNT_W = $clog2(MAX_WORDS + 1);
  localparam int ROW_W = ALPHA_SIZE * COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
  localparam logic [CNT_W-1:0] WC_FULL = CNT_W'(MAX_WORDS);

  logic [COUNT_BITS-1:0] cur_vec [ALPHA_SIZE];
  logic [ROW_W-1:0]      vec_mem [MAX_WORDS];
  logic [IDX_W-1:0]      ord_mem [MAX_WORDS];

  logic [CNT_W-1:0]     word_count;
  logic                 ovf;
  logic [ROW_W-1:0]     row_packed;
  logic [ROW_W-1:0]     vec_rdata;
  logic [IDX_W-1:0]     ord_rdata;
  logic [ROW_W-1:0]     cur_row;
  logic [ROW_W-1:0]     prev_row;
  logic [CNT_W-1:0]     i;
  logic [IDX_W-1:0]     j;
  logic [OUT_IDX_W-1:0] group;
  logic [OUT_IDX_W-1:0] group_next;
  logic                 start;
  logic                 full;
  letter_t              lt;

  logic                 out_valid;
  logic [OUT_IDX_W-1:0] out_word;
  logic [OUT_IDX_W-1:0] out_group;
  logic                 out_new;
  logic                 out_last;
  logic                 out_ovf;

  assign full = (word_count == WC_FULL);
  assign lt   = letter_of(char_code);

  // Pack with letter a most significant, so a plain compare is lexicographic
  always_comb begin
    for (int k = 0; k < ALPHA_SIZE; k++) begin
      row_packed[(ALPHA_SIZE-1-k)*COUNT_BITS +: COUNT_BITS] = cur_vec[k];
    end
  end

  // Current word letter counters
  always_ff @(posedge clk) begin
    if (rst || cmd.clear || cmd.close) begin
      for (int k = 0; k < ALPHA_SIZE; k++) begin
        cur_vec[k] <= '0;
      end
    end else if (cmd.char_upd && lt.hit && !full && cur_vec[lt.idx] != CMAX) begin
      cur_vec[lt.idx] <= cur_vec[lt.idx] + 1'b1;
    end
  end

  // Word count and overflow flag
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      word_count <= '0;
      ovf        <= 1'b0;
    end else begin
      if (cmd.close && !full) begin
        word_count <= word_count + 1'b1;
      end
      if ((cmd.close && full) ||
          (cmd.char_upd && lt.hit && !full && cur_vec[lt.idx] == CMAX)) begin
        ovf <= 1'b1;
      end
    end
  end

  // Vector store: write on close, one read port
  always_ff @(posedge clk) begin
    if (cmd.close && !full) begin
      vec_mem[word_count[IDX_W-1:0]] <= row_packed;
    end
    if (cmd.rd_vec_i) begin
      vec_rdata <= vec_mem[i[IDX_W-1:0]];
    end else if (cmd.rd_vec_ord) begin
      vec_rdata <= vec_mem[ord_rdata];
    end
  end

  // Sort order store
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      ord_mem[j] <= ord_rdata;
    end else if (cmd.place) begin
      ord_mem[j] <= i[IDX_W-1:0];
    end
    if (cmd.rd_ord_jm1) begin
      ord_rdata <= ord_mem[j - 1'b1];
    end else if (cmd.rd_ord_i) begin
      ord_rdata <= ord_mem[i[IDX_W-1:0]];
    end
  end

  // Group boundary of the word under report
  assign start      = (i == '0) || (vec_rdata != prev_row);
  assign group_next = (start && i != '0) ? group + 1'b1 : group;

  // Loop indexes and compare registers
  always_ff @(posedge clk) begin
    if (rst) begin
      i     <= '0;
      j     <= '0;
      group <= '0;
    end else begin
      if (cmd.i_zero) begin
        i     <= '0;
        group <= '0;
      end else if (cmd.place || cmd.emit) begin
        i <= i + 1'b1;
      end
      if (cmd.cap_cur) begin
        j <= i[IDX_W-1:0];
      end else if (cmd.shift) begin
        j <= j - 1'b1;
      end
      if (cmd.emit) begin
        group <= group_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_cur) begin
      cur_row <= vec_rdata;
    end
    if (cmd.emit) begin
      prev_row <= vec_rdata;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word  <= OUT_IDX_W'(ord_rdata);
      out_group <= group_next;
      out_new   <= start;
      out_last  <= sts.last;
      out_ovf   <= ovf;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.word_index  = out_word;
  assign out_ch.group_index = out_group;
  assign out_ch.new_group   = out_new;
  assign out_ch.last_result = out_last;
  assign out_ch.overflow    = out_ovf;

  // Status
  assign sts.wc_zero  = (word_count == '0);
  assign sts.i_eq_n   = (i == word_count);
  assign sts.i_zero   = (i == '0);
  assign sts.j_one    = (j == IDX_W'(1));
  assign sts.gt       = (vec_rdata > cur_row);
  assign sts.last     = ((i + 1'b1) == word_count);
  assign sts.out_free = !out_valid || out_ch.ready;

`ifndef ASSERT_OFF
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ch.ready))
    else $error("result loaded over an untaken beat");

  a_wc_range: assert property (@(posedge clk) disable iff (rst)
    word_count <= WC_FULL)
    else $error("word count beyond capacity");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (word_count == '0 && !ovf))
    else $error("store not cleared after finish");

  a_last_emit: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && sts.last) |-> cmd.clear)
    else $error("final result without store clear");
`endif

endmodule

>>> rtl/anagram_group_engine.sv
// ---------------------------------------------------------------------------
// anagram_group_engine: groups words by case-folded letter count vectors
// Counts letters per word, sorts the word vectors on finish, reports groups.
// ---------------------------------------------------------------------------
//   channel | dir | payload
//   in_ch   | in  | req_type[1:0], char_code[7:0]
//   out_ch  | out | word_index[5:0], group_index[5:0], new_group,
//           |     | last_result, overflow
//
// Character and close beats each make one counter update or one store write.
// A finish runs the insertion sort, each inner compare step reading the order
// store and then the single read port of the vector store, and then walks
// the sorted words to report them; result stalls hold up the walk.
// Input is held off from a finish until its last result is loaded into the
// output register. Reset is synchronous; no clearing pass is needed.
// ---------------------------------------------------------------------------
module anagram_group_engine
  import age_pkg::*;
#(
  parameter int MAX_WORDS  = DEF_MAX_WORDS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic      clk,
  input  logic      rst,
  age_in_if.sink    in_ch,
  age_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;

  age_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .req_type (in_ch.req_type),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  age_dp #(
    .MAX_WORDS  (MAX_WORDS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .char_code (in_ch.char_code),
    .cmd       (cmd),
    .sts       (sts),
    .out_ch    (out_ch)
  );

endmodule
